FILE: hdl/assert_macros.svh
// Assertion macros used by the checker of the slot pool allocator.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication into the following cycle, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/fspa_pkg.sv
// Shared types and constants of the fixed slot pool allocator.
// No dependencies; used by the controller, the datapath and the checker.
package fspa_pkg;

    localparam int SLOT_IN_W  = 10;
    localparam int ELEM_W     = 9;
    localparam int OFFSET_W   = 19;
    localparam int STRIDE_W   = 11;
    localparam int CMP_W      = SLOT_IN_W + 1;
    localparam int SLOT_LIMIT = 1024;

    localparam logic [ELEM_W-1:0]   ELEM_RESET  = 9'd4;
    localparam logic [STRIDE_W-1:0] ALIGN_MASK  = ~11'd3;
    localparam logic [STRIDE_W-1:0] ALIGN_ADD   = 11'd3;
    localparam logic [STRIDE_W-1:0] HDR_BYTES   = 11'd8;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX  = 19'h7FFFF;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SPACE    = 2'd1,
        ST_NOT_OWNED   = 2'd2,
        ST_DOUBLE_FREE = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic finish;
    } cmd_t;

endpackage

FILE: hdl/fixed_slot_pool_allocator_unit.sv
// Top level of the fixed slot pool allocator.
// Instantiates fspa_ctrl and fspa_datapath; depends on fspa_pkg.

// A request is taken when start is high while busy is low, and its single
// result appears, after the controller has passed S_EXEC and S_FINISH, as a
// one-cycle done strobe with status, slot_out and byte_offset valid in that
// cycle. The receiver cannot stall, so the result must be taken in the cycle
// it is shown. One request is in flight at a time and each runs in order: the
// accept cycle issues the registered read of the link and in-use stores, the
// S_EXEC state updates the free list and multiplies the slot by the stride,
// and the S_FINISH state adds the header and saturates. A new request may be
// started in the same cycle as the done strobe of the previous one.
// Allocation pops the most recently freed slot first and otherwise takes the
// next never-used slot; a free is checked against ownership and double free.
// No clearing pass runs after reset: the in-use store is only consulted below
// the bump count. The element size register is written over the cfg channel,
// which is always ready, and must be written only while the block is idle.
module fixed_slot_pool_allocator_unit
#(
    parameter int SLOTS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [9:0]  slot,
    output logic        done,
    output logic [1:0]  status,
    output logic [9:0]  slot_out,
    output logic [18:0] byte_offset,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);

    fspa_pkg::cmd_t cmd;

    // The configuration register accepts every transfer at once.
    assign cfg_ready = 1'b1;

    fspa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    fspa_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .slot        (slot),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .status      (status),
        .slot_out    (slot_out),
        .byte_offset (byte_offset)
    );

endmodule

FILE: hdl/fspa_ctrl.sv
// Controller state machine of the fixed slot pool allocator.
// Depends on fspa_pkg for the command struct.
module fspa_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output fspa_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign cmd.capture = start && (state_reg == S_IDLE);
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.finish  = (state_reg == S_FINISH);

endmodule

FILE: hdl/fspa_datapath.sv
// Datapath of the fixed slot pool allocator: free list, link and in-use stores,
// bump counter, element size register and offset arithmetic. Depends on fspa_pkg.
module fspa_datapath
#(
    parameter int SLOTS = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fspa_pkg::cmd_t                cmd,
    input  logic                          req_type,
    input  logic [fspa_pkg::SLOT_IN_W-1:0] slot,
    input  logic                          cfg_we,
    input  logic [fspa_pkg::ELEM_W-1:0]   cfg_data,
    output logic [1:0]                    status,
    output logic [fspa_pkg::SLOT_IN_W-1:0] slot_out,
    output logic [fspa_pkg::OFFSET_W-1:0] byte_offset
);

    localparam int CAP     = (SLOTS < fspa_pkg::SLOT_LIMIT) ? SLOTS : fspa_pkg::SLOT_LIMIT;
    localparam int SLOT_W  = $clog2(CAP);
    localparam int DEPTH   = 1 << SLOT_W;
    localparam int BUMP_W  = $clog2(CAP + 1);
    localparam int PROD_W  = fspa_pkg::SLOT_IN_W + fspa_pkg::STRIDE_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam logic [BUMP_W-1:0] CAP_COUNT = BUMP_W'(CAP);

    // Link store holds the next free slot and whether that link is valid.
    logic [SLOT_W:0] link_mem [DEPTH];
    logic            inuse_mem [DEPTH];

    logic [fspa_pkg::ELEM_W-1:0]    elem_size_reg;
    logic [SLOT_W-1:0]              free_head_reg;
    logic [SLOT_W-1:0]              free_head_next;
    logic                           nonempty_reg;
    logic                           nonempty_next;
    logic [BUMP_W-1:0]              bump_reg;
    logic [BUMP_W-1:0]              bump_next;

    logic                           req_reg;
    logic [fspa_pkg::SLOT_IN_W-1:0] slot_reg;
    logic [SLOT_W:0]                link_rd_reg;
    logic                           inuse_rd_reg;
    logic [SLOT_W-1:0]              rd_addr;

    fspa_pkg::status_t              res_status_reg;
    fspa_pkg::status_t              res_status_next;
    logic [fspa_pkg::SLOT_IN_W-1:0] res_slot_reg;
    logic [fspa_pkg::SLOT_IN_W-1:0] res_slot_next;
    logic [PROD_W-1:0]              prod_reg;
    logic [PROD_W-1:0]              prod_next;

    logic                           link_we;
    logic                           inuse_we;
    logic                           inuse_wdata;
    logic [SLOT_W-1:0]              wr_addr;
    logic [fspa_pkg::STRIDE_W-1:0]  stride;
    logic [SUM_W-1:0]               sum;

    logic [1:0]                     status_reg;
    logic [fspa_pkg::SLOT_IN_W-1:0] slot_out_reg;
    logic [fspa_pkg::OFFSET_W-1:0]  offset_reg;
    logic [fspa_pkg::OFFSET_W-1:0]  offset_next;

    assign rd_addr = (req_type == fspa_pkg::REQ_FREE) ? slot[SLOT_W-1:0] : free_head_reg;

    // Stores: registered read at capture, single write during execution.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            link_rd_reg  <= link_mem[rd_addr];
            inuse_rd_reg <= inuse_mem[rd_addr];
        end
        if (link_we)
        begin
            link_mem[wr_addr] <= {nonempty_reg, free_head_reg};
        end
        if (inuse_we)
        begin
            inuse_mem[wr_addr] <= inuse_wdata;
        end
    end

    always_comb
    begin
        stride = ((fspa_pkg::STRIDE_W'(elem_size_reg) + fspa_pkg::ALIGN_ADD)
                  & fspa_pkg::ALIGN_MASK) + fspa_pkg::HDR_BYTES;
    end

    // Request decision. The in-use store is only consulted for slots below the bump
    // count, all of which were written when first handed out.
    always_comb
    begin
        free_head_next  = free_head_reg;
        nonempty_next   = nonempty_reg;
        bump_next       = bump_reg;
        res_status_next = fspa_pkg::ST_OK;
        res_slot_next   = slot_reg;
        link_we         = 1'b0;
        inuse_we        = 1'b0;
        inuse_wdata     = 1'b0;
        wr_addr         = slot_reg[SLOT_W-1:0];
        if (req_reg == fspa_pkg::REQ_ALLOC)
        begin
            if (nonempty_reg)
            begin
                wr_addr       = free_head_reg;
                res_slot_next = fspa_pkg::SLOT_IN_W'(free_head_reg);
                inuse_we      = cmd.exec;
                inuse_wdata   = 1'b1;
                if (link_rd_reg[SLOT_W])
                begin
                    free_head_next = link_rd_reg[SLOT_W-1:0];
                end
                else
                begin
                    free_head_next = '0;
                    nonempty_next  = 1'b0;
                end
            end
            else if (bump_reg < CAP_COUNT)
            begin
                wr_addr       = bump_reg[SLOT_W-1:0];
                res_slot_next = fspa_pkg::SLOT_IN_W'(bump_reg);
                inuse_we      = cmd.exec;
                inuse_wdata   = 1'b1;
                bump_next     = bump_reg + 1'b1;
            end
            else
            begin
                res_status_next = fspa_pkg::ST_NO_SPACE;
                res_slot_next   = '0;
            end
        end
        else
        begin
            if (fspa_pkg::CMP_W'(slot_reg) >= fspa_pkg::CMP_W'(bump_reg))
            begin
                res_status_next = fspa_pkg::ST_NOT_OWNED;
            end
            else if (!inuse_rd_reg)
            begin
                res_status_next = fspa_pkg::ST_DOUBLE_FREE;
            end
            else
            begin
                link_we        = cmd.exec;
                inuse_we       = cmd.exec;
                inuse_wdata    = 1'b0;
                free_head_next = slot_reg[SLOT_W-1:0];
                nonempty_next  = 1'b1;
            end
        end
        prod_next = PROD_W'(res_slot_next) * PROD_W'(stride);
    end

    always_comb
    begin
        sum = SUM_W'(prod_reg) + SUM_W'(fspa_pkg::HDR_BYTES);
        if (res_status_reg != fspa_pkg::ST_OK)
        begin
            offset_next = '0;
        end
        else if (sum > SUM_W'(fspa_pkg::OFFSET_MAX))
        begin
            offset_next = fspa_pkg::OFFSET_MAX;
        end
        else
        begin
            offset_next = sum[fspa_pkg::OFFSET_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_size_reg <= fspa_pkg::ELEM_RESET;
            free_head_reg <= '0;
            nonempty_reg  <= 1'b0;
            bump_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                elem_size_reg <= cfg_data;
            end
            if (cmd.exec)
            begin
                free_head_reg <= free_head_next;
                nonempty_reg  <= nonempty_next;
                bump_reg      <= bump_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            slot_reg <= slot;
        end
        if (cmd.exec)
        begin
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            prod_reg       <= prod_next;
        end
        if (cmd.finish)
        begin
            status_reg   <= res_status_reg;
            slot_out_reg <= res_slot_reg;
            offset_reg   <= offset_next;
        end
    end

    assign status      = status_reg;
    assign slot_out    = slot_out_reg;
    assign byte_offset = offset_reg;

endmodule

FILE: hdl/fspa_checker.sv
// Port-level checker of the fixed slot pool allocator and its bind.
// Depends on fspa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fspa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [18:0] byte_offset
);

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_SAME(a_finish_done, clk, rst_n, $fell(busy), done)
    `ASSERT_SAME(a_err_offset, clk, rst_n, done && (status != fspa_pkg::ST_OK), byte_offset == '0)

endmodule

bind fixed_slot_pool_allocator_unit fspa_checker u_fspa_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .byte_offset (byte_offset)
);
